FILE: src/rdrs_pkg.sv
// Shared constants, types and helpers of the receive descriptor ring scanner.
// No dependencies; the scanner and the ring store refer to it by scoped names.
package rdrs_pkg;

	localparam int RING_SLOTS  = 16;
	localparam int IDX_BITS    = $clog2(RING_SLOTS);
	localparam int LENGTH_BITS = 11;
	localparam int BUDGET_BITS = $clog2(RING_SLOTS + 1);
	// start mark, end mark and length as held in the marks memory
	localparam int MARKS_BITS  = 2 + LENGTH_BITS;

	typedef logic [IDX_BITS-1:0]    idx_t;
	typedef logic [LENGTH_BITS-1:0] len_t;
	typedef logic [BUDGET_BITS-1:0] budget_t;

	localparam logic [1:0] CMD_FILL    = 2'd0;
	localparam logic [1:0] CMD_GET     = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	// One descriptor as read back from the ring
	typedef struct packed {
		logic owned;
		logic sof;
		logic eof;
		len_t len;
	} desc_t;

	// Access request from the sequencer to the ring store
	typedef struct packed {
		idx_t rd_addr;
		logic own_we;
		logic fill_we;
		idx_t wr_addr;
		logic wr_owned;
		logic wr_sof;
		logic wr_eof;
		len_t wr_len;
	} ring_req_t;

	function automatic idx_t next_idx(idx_t i);
		return (i == idx_t'(RING_SLOTS - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

endpackage

FILE: src/rx_descriptor_ring_scanner.sv
// Receive descriptor ring scanner: command sequencer over the ring store (rdrs_ring).
// Fill and no-op give their result in the cycle after acceptance. Release frees the
// slots from the given one through its end mark, at most 16, and sets the read pointer
// past them. Get walks the ring from the read pointer, one slot at a time through the
// single ring read port, dropping partial frames on the way. One command at a time.
// Reset clears valid bits and read pointer at once; the block is ready straight away.
module rx_descriptor_ring_scanner (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           command,
	input  rdrs_pkg::idx_t       slot,
	input  logic                 frame_start,
	input  logic                 frame_end,
	input  rdrs_pkg::len_t       length,
	output logic                 done,
	output logic                 status,
	output rdrs_pkg::idx_t       first_slot,
	output rdrs_pkg::len_t       frame_length,
	output rdrs_pkg::idx_t       next_slot
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DROP = 2'd2;
	localparam logic [1:0] ST_REL  = 2'd3;

	logic [1:0]          state_q, state_d;
	rdrs_pkg::idx_t      rp_q, rp_d;
	rdrs_pkg::idx_t      head_q, head_d;
	rdrs_pkg::budget_t   budget_q, budget_d;
	logic                build_q, build_d;
	logic                drop_build_q, drop_build_d;
	logic                done_q, done_d;
	logic                status_q, status_d;
	rdrs_pkg::idx_t      first_q, first_d;
	rdrs_pkg::len_t      flen_q, flen_d;
	rdrs_pkg::idx_t      next_q, next_d;

	rdrs_pkg::ring_req_t req;
	rdrs_pkg::desc_t     desc;
	rdrs_pkg::idx_t      rp_inc, head_inc;
	rdrs_pkg::budget_t   budget_dec;

	rdrs_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (desc)
	);

	assign rp_inc     = rdrs_pkg::next_idx(rp_q);
	assign head_inc   = rdrs_pkg::next_idx(head_q);
	assign budget_dec = budget_q - rdrs_pkg::budget_t'(1);

	always_comb begin
		req          = '0;
		req.rd_addr  = rp_q;
		state_d      = state_q;
		rp_d         = rp_q;
		head_d       = head_q;
		budget_d     = budget_q;
		build_d      = build_q;
		drop_build_d = drop_build_q;
		done_d       = 1'b0;
		status_d     = status_q;
		first_d      = first_q;
		flen_d       = flen_q;
		next_d       = next_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (command)
						rdrs_pkg::CMD_FILL: begin
							req.fill_we  = 1'b1;
							req.own_we   = 1'b1;
							req.wr_addr  = slot;
							req.wr_owned = 1'b1;
							req.wr_sof   = frame_start;
							req.wr_eof   = frame_end;
							req.wr_len   = length;
							done_d       = 1'b1;
							status_d     = 1'b0;
							first_d      = '0;
							flen_d       = '0;
							next_d       = rp_q;
						end
						rdrs_pkg::CMD_GET: begin
							// ring read of the pointer slot is issued now
							state_d  = ST_SCAN;
							budget_d = rdrs_pkg::budget_t'(rdrs_pkg::RING_SLOTS);
							build_d  = 1'b0;
						end
						rdrs_pkg::CMD_RELEASE: begin
							state_d     = ST_REL;
							head_d      = slot;
							budget_d    = rdrs_pkg::budget_t'(rdrs_pkg::RING_SLOTS);
							req.rd_addr = slot;
						end
						default: begin
							done_d   = 1'b1;
							status_d = 1'b0;
							first_d  = '0;
							flen_d   = '0;
							next_d   = rp_q;
						end
					endcase
				end
			end

			ST_SCAN: begin
				req.rd_addr = rp_inc;
				if (budget_q == '0) begin
					// scan budget spent: no complete frame
					state_d  = ST_IDLE;
					done_d   = 1'b1;
					status_d = 1'b1;
					first_d  = '0;
					flen_d   = '0;
					next_d   = rp_q;
				end else if (!build_q) begin
					if (desc.owned && desc.sof && desc.eof) begin
						state_d  = ST_IDLE;
						done_d   = 1'b1;
						status_d = 1'b0;
						first_d  = rp_q;
						flen_d   = desc.len;
						next_d   = rp_q;
					end else begin
						// free an orphan fragment, open a frame on a start mark
						if (desc.owned && !desc.sof) begin
							req.own_we   = 1'b1;
							req.wr_addr  = rp_q;
							req.wr_owned = 1'b0;
						end
						if (desc.owned && desc.sof) begin
							head_d  = rp_q;
							build_d = 1'b1;
						end
						rp_d     = rp_inc;
						budget_d = budget_dec;
					end
				end else begin
					if (!desc.owned) begin
						// hole: drop the partial frame, then skip this slot
						state_d      = ST_DROP;
						drop_build_d = 1'b0;
					end else if (desc.eof) begin
						state_d  = ST_IDLE;
						done_d   = 1'b1;
						status_d = 1'b0;
						first_d  = head_q;
						flen_d   = desc.len;
						next_d   = rp_q;
					end else if (desc.sof) begin
						// second start: drop the partial frame, restart here
						state_d      = ST_DROP;
						drop_build_d = 1'b1;
					end else begin
						rp_d     = rp_inc;
						budget_d = budget_dec;
					end
				end
			end

			ST_DROP: begin
				req.own_we   = 1'b1;
				req.wr_addr  = head_q;
				req.wr_owned = 1'b0;
				req.rd_addr  = rp_inc;
				head_d       = head_inc;
				if (head_inc == rp_q) begin
					state_d  = ST_SCAN;
					head_d   = rp_q;
					build_d  = drop_build_q;
					rp_d     = rp_inc;
					budget_d = budget_dec;
				end
			end

			ST_REL: begin
				req.own_we   = 1'b1;
				req.wr_addr  = head_q;
				req.wr_owned = 1'b0;
				req.rd_addr  = head_inc;
				head_d       = head_inc;
				budget_d     = budget_dec;
				if (desc.eof || (budget_q == rdrs_pkg::budget_t'(1))) begin
					state_d  = ST_IDLE;
					rp_d     = head_inc;
					done_d   = 1'b1;
					status_d = 1'b0;
					first_d  = '0;
					flen_d   = '0;
					next_d   = head_inc;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rp_q         <= '0;
			budget_q     <= '0;
			build_q      <= 1'b0;
			drop_build_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			rp_q         <= rp_d;
			budget_q     <= budget_d;
			build_q      <= build_d;
			drop_build_q <= drop_build_d;
			done_q       <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q   <= head_d;
		status_q <= status_d;
		first_q  <= first_d;
		flen_q   <= flen_d;
		next_q   <= next_d;
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign first_slot   = first_q;
	assign frame_length = flen_q;
	assign next_slot    = next_q;

	// An accepted request either answers at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request neither answered nor in progress");

	// Leaving a walk always delivers a result
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk finished without a result");

	// A drop never reaches the scan position
	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DROP) |-> (head_q != rp_q))
		else $error("drop pointer met the read pointer");

	// A release walk never runs past one ring's worth of slots
	a_rel_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REL) |-> (budget_q != '0))
		else $error("release walked beyond the ring");

endmodule

FILE: src/rdrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// A read of the entry being written in the same cycle returns the new data.
// No dependencies.
module rdrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [WIDTH-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [WIDTH-1:0]             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// forward a same-cycle write to the read port
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/rdrs_ring.sv
// Descriptor ring store: owned-flag memory, marks/length memory and fill valid bits.
// Depends on rdrs_pkg and rdrs_ram.
module rdrs_ring (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rdrs_pkg::ring_req_t   req,
	output rdrs_pkg::desc_t       rsp
);

	logic [rdrs_pkg::RING_SLOTS-1:0] filled_q;
	logic                            rd_valid_q;
	logic                            own_rd;
	logic [rdrs_pkg::MARKS_BITS-1:0] marks_rd;

	rdrs_ram #(
		.WIDTH (1),
		.DEPTH (rdrs_pkg::RING_SLOTS)
	) u_own_ram (
		.clk   (clk),
		.we    (req.own_we),
		.waddr (req.wr_addr),
		.wdata (req.wr_owned),
		.raddr (req.rd_addr),
		.rdata (own_rd)
	);

	rdrs_ram #(
		.WIDTH (rdrs_pkg::MARKS_BITS),
		.DEPTH (rdrs_pkg::RING_SLOTS)
	) u_marks_ram (
		.clk   (clk),
		.we    (req.fill_we),
		.waddr (req.wr_addr),
		.wdata ({req.wr_sof, req.wr_eof, req.wr_len}),
		.raddr (req.rd_addr),
		.rdata (marks_rd)
	);

	// An entry never filled since reset reads as all clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q   <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.fill_we) begin
				filled_q[req.wr_addr] <= 1'b1;
			end
			rd_valid_q <= filled_q[req.rd_addr] |
				(req.fill_we && (req.wr_addr == req.rd_addr));
		end
	end

	always_comb begin
		rsp = rd_valid_q ? rdrs_pkg::desc_t'({own_rd, marks_rd}) : '0;
	end

endmodule
